[src/capture_probability_normalizer_defines.svh]
// Assertion macros shared by the capture probability normalizer RTL.
// Each macro uses the module's clock and reset names.
`ifndef CAPTURE_PROBABILITY_NORMALIZER_DEFINES_SVH
`define CAPTURE_PROBABILITY_NORMALIZER_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define CPN_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("capture_probability_normalizer: check failed");

// antecedent holds -> consequent holds in the next cycle
`define CPN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("capture_probability_normalizer: check failed");

`endif

[src/cpn_pkg.sv]
// Package for the capture probability normalizer: widths, constants,
// sequencer states and the structs passed between the units.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpn_pkg;

   localparam int CNT_W          = 16;
   localparam int PROB_W         = 17;
   localparam int FRAC_W         = 16;
   localparam int OP_W           = 17;
   localparam int PROD_W         = 2 * OP_W;
   localparam int SUM_W          = 38;
   localparam int RATIO_W        = 32;
   localparam int QUO_W          = OP_W + FRAC_W;
   localparam int REQ_TDATA_W    = 40;
   localparam int DEF_COUNT_BITS = 16;

   localparam logic [OP_W-1:0] ONE_Q16 = OP_W'(1 << FRAC_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ,
      ST_MB,
      ST_UPD,
      ST_SUM,
      ST_ACC,
      ST_CHK,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic            en;
      logic [OP_W-1:0] a;
      logic [OP_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

[src/cpn_mul.sv]
// Shared 17x17 multiplier with a registered product.
// Depends on cpn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpn_mul
   import cpn_pkg::*;
(
   input  wire logic              clock,
   input  wire mul_req_type       mul_req,
   output logic [PROD_W-1:0]      mul_prod
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in  = PROD_W'(mul_req.a) * PROD_W'(mul_req.b);
   assign mul_prod = prod_ff;

   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

[src/cpn_div.sv]
// Restoring divider, one quotient bit per cycle; done holds until the next start.
// Depends on cpn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpn_div
   import cpn_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              div_start,
   input  wire logic [QUO_W-1:0]  dividend,
   input  wire logic [SUM_W-1:0]  divisor,
   output div_rsp_type            div_rsp
);

   localparam int STEP_W = $clog2(QUO_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [SUM_W-1:0]  dvs_ff, dvs_in;

   logic [SUM_W:0]    shifted;
   logic [SUM_W+1:0]  diff;

   assign shifted = {rem_ff, quo_ff[QUO_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = STEP_W'(QUO_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // borrow set: keep the shifted remainder, quotient bit 0
         if (diff[SUM_W+1]) begin
            rem_in = shifted[SUM_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end else begin
            rem_in = diff[SUM_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

[src/capture_probability_normalizer.sv]
// Top level of the capture probability normalizer: sequencer, state
// registers and output register. Uses cpn_pkg, cpn_mul, cpn_div.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | req_tdata, req_tlast (row end)
//   rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata, rsp_tuser (zero sum)
//
// Each pair runs the square and base-multiply states, then product update,
// weight and accumulate: one shared multiplier does every square, base
// multiply, product update and weight. The last pair of a row adds a check
// state, then the bit-serial divide when the sum is nonzero.
// reset is synchronous; sum clears to 0, miss product to 1.0.
// A waiting result sits in the output register; the next row's pairs are
// still taken, only the next result waits for rsp_tready.
`timescale 1ns / 1ps
`default_nettype none

`include "capture_probability_normalizer_defines.svh"

module capture_probability_normalizer
   import cpn_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,   // item_count[15:0], capture_prob[32:16]
   input  wire logic                    req_tlast,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RATIO_W-1:0]           rsp_tdata,   // normalized_ratio[31:0]
   output logic                         rsp_tuser    // zero_sum[0]
);

   localparam int IDX_W  = (COUNT_BITS > 1) ? $clog2(COUNT_BITS) : 1;
   localparam int WIDE_W = COUNT_BITS + CNT_W;
   localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(COUNT_BITS - 1);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [OP_W-1:0]       prob_ff, prob_in;
   logic [OP_W-1:0]       base_ff, base_in;
   logic [COUNT_BITS-1:0] exp_ff, exp_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  last_ff, last_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [OP_W-1:0]       mp_ff, mp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RATIO_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                  rsp_zero_ff, rsp_zero_in;

   mul_req_type           mul_req;
   logic [PROD_W-1:0]     mul_prod;
   logic [OP_W-1:0]       prod_hi;
   div_rsp_type           div_rsp;
   logic                  div_start;
   logic [QUO_W-1:0]      dividend;

   logic                  accept;
   logic                  wb_go;
   logic                  round_end;
   logic [PROB_W-1:0]     prob_raw;
   logic [OP_W-1:0]       prob_clamp;
   logic [WIDE_W-1:0]     cnt_wide;
   logic [COUNT_BITS-1:0] exp_sat;
   logic [SUM_W:0]        sum_add;
   logic                  sum_zero;

   cpn_mul u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (mul_prod)
   );

   cpn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (dividend),
      .divisor   (sum_ff),
      .div_rsp   (div_rsp)
   );

   assign prod_hi  = mul_prod[FRAC_W+OP_W-1:FRAC_W];
   assign prob_raw = req_tdata[CNT_W+PROB_W-1:CNT_W];
   assign prob_clamp = (prob_raw > ONE_Q16) ? ONE_Q16 : prob_raw;
   assign cnt_wide = WIDE_W'(req_tdata[CNT_W-1:0]);
   assign exp_sat  = ((cnt_wide >> COUNT_BITS) != '0) ? '1 : cnt_wide[COUNT_BITS-1:0];
   assign sum_add  = {1'b0, sum_ff} + (SUM_W+1)'(mul_prod);
   assign sum_zero = (sum_ff == '0);
   assign dividend = {ONE_Q16 - mp_ff, FRAC_W'(0)};
   assign accept   = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SQ;
         end
         ST_SQ: begin
            if (exp_ff[COUNT_BITS-1]) state_in = ST_MB;
            else if (idx_ff == '0)    state_in = ST_UPD;
         end
         ST_MB: begin
            state_in = (idx_ff == '0) ? ST_UPD : ST_SQ;
         end
         ST_UPD: state_in = ST_SUM;
         ST_SUM: state_in = ST_ACC;
         ST_ACC: begin
            state_in = last_ff ? ST_CHK : ST_IDLE;
         end
         ST_CHK: begin
            if (wb_go && sum_zero)  state_in = ST_IDLE;
            else if (!sum_zero)     state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done && wb_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      mul_req    = '0;
      div_start  = 1'b0;
      round_end  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_SQ: begin
            mul_req.en = 1'b1;
            // first square of the run starts from 1.0
            mul_req.a  = (idx_ff == IDX_TOP) ? ONE_Q16 : prod_hi;
            mul_req.b  = (idx_ff == IDX_TOP) ? ONE_Q16 : prod_hi;
            round_end  = !exp_ff[COUNT_BITS-1];
         end
         ST_MB: begin
            mul_req.en = 1'b1;
            mul_req.a  = prod_hi;
            mul_req.b  = base_ff;
            round_end  = 1'b1;
         end
         ST_UPD: begin
            mul_req.en = 1'b1;
            mul_req.a  = mp_ff;
            mul_req.b  = prod_hi;
         end
         ST_SUM: begin
            mul_req.en = 1'b1;
            mul_req.a  = OP_W'(cnt_ff);
            mul_req.b  = prob_ff;
         end
         ST_ACC: ;
         ST_CHK: div_start = !sum_zero;
         ST_DIV: ;
         default: ;
      endcase
   end

   assign wb_go = !rsp_valid_ff || rsp_tready;

   // datapath registers
   always_comb begin
      cnt_in       = cnt_ff;
      prob_in      = prob_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      mp_in        = mp_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_zero_in  = rsp_zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (accept) begin
         cnt_in  = req_tdata[CNT_W-1:0];
         prob_in = prob_clamp;
         base_in = ONE_Q16 - prob_clamp;
         exp_in  = exp_sat;
         idx_in  = IDX_TOP;
         last_in = req_tlast;
      end
      if (round_end) begin
         exp_in = exp_ff << 1;
         idx_in = idx_ff - IDX_W'(1);
      end
      // a zero product stays zero through the update, no bypass needed
      if (state_ff == ST_SUM) mp_in = prod_hi;
      if (state_ff == ST_ACC) begin
         sum_in = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      end

      if (wb_go && ((state_ff == ST_CHK && sum_zero) ||
                    (state_ff == ST_DIV && div_rsp.done))) begin
         rsp_valid_in = 1'b1;
         rsp_zero_in  = sum_zero;
         rsp_data_in  = (sum_zero || div_rsp.quotient[QUO_W-1]) ? '1 :
                        div_rsp.quotient[RATIO_W-1:0];
         sum_in       = '0;
         mp_in        = ONE_Q16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         mp_ff        <= ONE_Q16;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         mp_ff        <= mp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      prob_ff     <= prob_in;
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_zero_ff;

   `CPN_ASSERT_NOW(a_zero_sum_sat, rsp_tvalid && rsp_tuser, rsp_tdata == '1)
   `CPN_ASSERT_NOW(a_mp_range, 1'b1, mp_ff <= ONE_Q16)
   `CPN_ASSERT_NOW(a_first_square, state_ff == ST_SQ && idx_ff == IDX_TOP,
                   $past(state_ff) == ST_IDLE)
   `CPN_ASSERT_NEXT(a_row_clear, state_ff == ST_DIV && div_rsp.done && wb_go,
                    sum_ff == '0 && mp_ff == ONE_Q16 && rsp_tvalid)

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for capture_probability_normalizer: sends rows of count/probability
// words, predicts each row's Q16.16 ratio and checks every result word.
// Depends on cpn_pkg and the normalizer RTL.
module tb_top
   import cpn_pkg::*;
();

   localparam int          STALL_LIMIT = 5000;
   localparam int          TAIL_CYCLES = 150;
   localparam logic [63:0] SUM_CAP     = (64'd1 << SUM_W) - 64'd1;
   localparam logic [63:0] RATIO_CAP   = 64'hFFFF_FFFF;

   typedef struct packed {
      logic [RATIO_W-1:0] ratio;
      logic               zero_sum;
   } ratio_word_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // item_count[15:0], capture_prob[32:16]
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RATIO_W-1:0]     rsp_tdata;   // normalized_ratio[31:0]
   logic                   rsp_tuser;   // zero_sum[0]

   ratio_word_type    pending_ratios[$];
   logic [SUM_W-1:0]  row_sum;
   logic [PROB_W-1:0] row_miss;
   int                errors;
   int                sent_pairs;
   int                burst_left;
   bit                sender_bursty;
   bit                rsp_steady;
   int                rsp_hold;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   capture_probability_normalizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // (1 - p) ^ n by square-and-multiply from the top bit, truncating each step
   function automatic logic [PROB_W-1:0] miss_power(input logic [PROB_W-1:0] base,
                                                    input logic [CNT_W-1:0]  expo);
      logic [63:0] r;
      r = 64'(ONE_Q16);
      for (int b = CNT_W - 1; b >= 0; b--) begin
         r = (r * r) >> FRAC_W;
         if (expo[b]) begin
            r = (r * 64'(base)) >> FRAC_W;
         end
      end
      return r[PROB_W-1:0];
   endfunction

   function automatic void absorb_pair(input logic [CNT_W-1:0]  cnt,
                                       input logic [PROB_W-1:0] prob,
                                       input logic              last);
      logic [PROB_W-1:0] p;
      logic [63:0]       s;
      logic [63:0]       num;
      logic [63:0]       q;
      ratio_word_type    w;
      p = (prob > ONE_Q16) ? ONE_Q16 : prob;
      s = 64'(row_sum) + 64'(cnt) * 64'(p);
      row_sum = (s > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : s[SUM_W-1:0];
      // a zero product is sticky
      if (row_miss != '0) begin
         q = (64'(row_miss) * 64'(miss_power(ONE_Q16 - p, cnt))) >> FRAC_W;
         row_miss = q[PROB_W-1:0];
      end
      if (last) begin
         if (row_sum == '0) begin
            w.ratio    = '1;
            w.zero_sum = 1'b1;
         end else begin
            num        = 64'(ONE_Q16) - 64'(row_miss);
            q          = (num << FRAC_W) / 64'(row_sum);
            w.ratio    = (q > RATIO_CAP) ? '1 : q[RATIO_W-1:0];
            w.zero_sum = 1'b0;
         end
         pending_ratios.push_back(w);
         row_sum  = '0;
         row_miss = ONE_Q16;
      end
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // called at a falling edge, returns at a falling edge with tvalid still high
   task automatic send_pair(input logic [CNT_W-1:0]  cnt,
                            input logic [PROB_W-1:0] prob,
                            input logic              last);
      int gap;
      if (sender_bursty && burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_tdata  = REQ_TDATA_W'({prob, cnt});
      req_tlast  = last;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      absorb_pair(cnt, prob, last);
      sent_pairs++;
      @(negedge clock);
   endtask

   task automatic drain_rows();
      req_tvalid = 1'b0;
      req_tlast  = 1'b0;
      while (pending_ratios.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic logic [CNT_W-1:0] random_count();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return CNT_W'($urandom_range(1, 15));
         2: return CNT_W'($urandom_range(16'hFFF0, 16'hFFFF));
         default: return CNT_W'($urandom);
      endcase
   endfunction

   function automatic logic [PROB_W-1:0] random_prob();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return ONE_Q16;
         2: return PROB_W'($urandom_range(17'h10001, 17'h1FFFF));  // above 1.0
         3: return PROB_W'($urandom_range(1, 255));
         4: return PROB_W'($urandom_range(65000, 65535));
         default: return PROB_W'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic test_directed();
      send_pair(16'd0, 17'd0, 1'b1);              // nothing at all: zero sum
      send_pair(16'd0, ONE_Q16, 1'b1);            // zero count
      send_pair(16'hFFFF, 17'd0, 1'b1);           // zero probability, max count
      send_pair(16'd1, 17'd1, 1'b1);              // smallest nonzero sum
      send_pair(16'd1, ONE_Q16, 1'b1);            // certain capture
      send_pair(16'd3, 17'h1FFFF, 1'b1);          // probability above one
      send_pair(16'd2, 17'h10001, 1'b0);
      send_pair(16'd5, 17'd1000, 1'b1);
      send_pair(16'hFFFF, 17'd1, 1'b1);
      send_pair(16'hFFFF, 17'hFFFF, 1'b1);
      send_pair(16'hFFFF, 17'h1ABCD, 1'b1);
      send_pair(16'hAAAA, 17'h0AAAA, 1'b0);
      send_pair(16'h5555, 17'h15555, 1'b1);
      send_pair(16'd10, 17'd30000, 1'b0);
      send_pair(16'd20, 17'd5000, 1'b0);
      send_pair(16'd0, 17'd12345, 1'b0);
      send_pair(16'd7, 17'd65535, 1'b1);
      // product hits zero, later pairs must not revive it
      send_pair(16'd1, ONE_Q16, 1'b0);
      send_pair(16'd40, 17'd200, 1'b0);
      send_pair(16'd1, 17'd1, 1'b1);
      drain_rows();
   endtask

   // long rows of 70 to 100 pairs; the first two are heavy enough that the sum saturates
   task automatic test_long_rows();
      int len;
      for (int r = 0; r < 3; r++) begin
         len = (r == 2) ? 100 : $urandom_range(70, 80);
         for (int i = 0; i < len; i++) begin
            if (r == 2) begin
               send_pair(random_count(), random_prob(), i == len - 1);
            end else begin
               send_pair(CNT_W'($urandom_range(16'hFF00, 16'hFFFF)),
                         PROB_W'($urandom_range(17'h10000, 17'h1FFFF)), i == len - 1);
            end
         end
      end
      drain_rows();
   endtask

   task automatic test_random_rows(input int target);
      int len;
      while (sent_pairs < target) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            send_pair(random_count(), random_prob(), i == len - 1);
         end
      end
      drain_rows();
   endtask

   // receiver holds off while short rows keep coming, so the input stalls
   task automatic test_backpressure();
      int len;
      sender_bursty = 1'b0;
      rsp_hold      = 1500;
      for (int r = 0; r < 30; r++) begin
         len = $urandom_range(1, 3);
         for (int i = 0; i < len; i++) begin
            send_pair(random_count(), random_prob(), i == len - 1);
         end
      end
      drain_rows();
      sender_bursty = 1'b1;
   endtask

   task automatic test_steady();
      int len;
      sender_bursty = 1'b0;
      rsp_steady    = 1'b1;
      for (int r = 0; r < 40; r++) begin
         len = $urandom_range(1, 4);
         for (int i = 0; i < len; i++) begin
            send_pair(random_count(), random_prob(), i == len - 1);
         end
      end
      drain_rows();
      sender_bursty = 1'b1;
      rsp_steady    = 1'b0;
   endtask

   // receiver: random short stalls, steady mode, or a long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_tready = 1'b0;
            rsp_hold--;
         end else if (rsp_steady) begin
            rsp_tready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            stall_left = $urandom_range(0, 9);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      ratio_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_ratios.size() == 0) begin
            flag_mismatch("unexpected result word", 64'({rsp_tuser, rsp_tdata}), 64'd0);
         end else begin
            want = pending_ratios.pop_front();
            if (rsp_tdata !== want.ratio) begin
               flag_mismatch("normalized_ratio", 64'(rsp_tdata), 64'(want.ratio));
            end
            if (rsp_tuser !== want.zero_sum) begin
               flag_mismatch("zero_sum", 64'(rsp_tuser), 64'(want.zero_sum));
            end
         end
      end
   end

   // watchdog: too long without a word moving on either side
   initial begin
      int quiet;
      quiet = 0;
      @(negedge reset);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      rsp_hold      = 0;
      rsp_steady    = 1'b0;
      sender_bursty = 1'b1;
      burst_left    = 0;
      row_sum       = '0;
      row_miss      = ONE_Q16;
      errors        = 0;
      sent_pairs    = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_long_rows();
      test_random_rows(1400);
      test_backpressure();
      test_steady();

      drain_rows();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/cpn_pkg.sv
src/cpn_mul.sv
src/cpn_div.sv
src/capture_probability_normalizer.sv
dv/tb_top.sv
